// ===== rtl/tfr_pkg.sv =====
// Shared types and constants for the touch frame receiver.
package tfr_pkg;

   // Framing bytes
   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] TAIL_BYTE   = 8'hAA;

   // Frame status codes
   localparam logic [2:0] ST_KEY     = 3'd0;
   localparam logic [2:0] ST_OTHER   = 3'd1;
   localparam logic [2:0] ST_SUMERR  = 3'd2;
   localparam logic [2:0] ST_TAILERR = 3'd3;
   localparam logic [2:0] ST_TOOLONG = 3'd4;

   // Register indexes and reset values
   localparam int unsigned CSR_IDX_W  = 8;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_OPCODE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LIMIT  = 8'd1;
   localparam logic [7:0] KEY_OPCODE_RESET = 8'h28;
   localparam logic [8:0] KEY_LIMIT_RESET  = 9'd40;

   // Parser phase, one-hot
   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_LEN  = 5'b00010,
      PH_DATA = 5'b00100,
      PH_SUM  = 5'b01000,
      PH_TAIL = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_beat_type;

   typedef struct packed {
      logic [2:0] frame_status;
      logic [7:0] key_code;
      logic [7:0] command_byte;
   } rsp_beat_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [8:0]           data;
   } csr_beat_type;

   // Parser result toward the output register
   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } parse_res_type;

endpackage

// ===== rtl/tfr_chan_if.sv =====
// Valid/ready channel carrying one beat of a given payload type.
interface tfr_chan_if #(
   parameter type PAYLOAD_TYPE = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/tfr_parser.sv =====
// Frame phase machine: header hunt, length, payload sum, checksum and tail check.
module tfr_parser
   import tfr_pkg::*;
#(
   parameter int unsigned PAYLOAD_DEPTH = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    rx_byte,
   input  logic [7:0]    key_opcode,
   input  logic [8:0]    key_limit,
   output parse_res_type res
);

   localparam logic [7:0] DEPTH_BYTE = 8'(PAYLOAD_DEPTH);

   phase_type  phase_ff, phase_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] cmd_ff, cmd_in;   // payload byte 0
   logic [7:0] key_ff, key_in;   // payload byte 1
   logic [7:0] count_inc;

   assign count_inc = count_ff + 8'd1;

   // Next state and result for the byte in hand
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      res      = '0;
      res.beat.key_code     = key_ff;
      res.beat.command_byte = cmd_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == HEADER_BYTE) begin
               cmd_in   = '0;
               key_in   = '0;
               sum_in   = '0;
               count_in = '0;
               len_in   = '0;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            len_in   = rx_byte;
            count_in = '0;
            if (rx_byte > DEPTH_BYTE) begin
               // over-long length: store reads as cleared
               cmd_in                = '0;
               key_in                = '0;
               res.valid             = 1'b1;
               res.beat.frame_status = ST_TOOLONG;
               res.beat.key_code     = '0;
               res.beat.command_byte = '0;
               phase_in              = PH_HUNT;
            end else if (rx_byte == 8'd0) begin
               phase_in = PH_SUM;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (count_ff == 8'd0) cmd_in = rx_byte;
            if (count_ff == 8'd1) key_in = rx_byte;
            sum_in   = sum_ff + rx_byte;
            count_in = count_inc;
            if (count_inc >= len_ff) phase_in = PH_SUM;
         end
         PH_SUM: begin
            if (rx_byte != sum_ff) begin
               res.valid             = 1'b1;
               res.beat.frame_status = ST_SUMERR;
               phase_in              = PH_HUNT;
            end else begin
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            res.valid = 1'b1;
            phase_in  = PH_HUNT;
            if (rx_byte != TAIL_BYTE) begin
               res.beat.frame_status = ST_TAILERR;
            end else if (cmd_ff == key_opcode && {1'b0, key_ff} < key_limit) begin
               res.beat.frame_status = ST_KEY;
            end else begin
               res.beat.frame_status = ST_OTHER;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         cmd_ff   <= '0;
         key_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         cmd_ff   <= cmd_in;
         key_ff   <= key_in;
      end
   end

endmodule

// ===== rtl/touch_frame_receiver.sv =====
// Top level of the touch frame receiver: input stage, parser, result register, CSRs.
//
//   channel  dir  beat contents                          accepted when
//   req_ch   in   rx_byte                                valid && ready
//   rsp_ch   out  frame_status, key_code, command_byte   valid && ready
//   csr_ch   in   index, data (0 key_opcode, 1 key_limit) valid && ready (always ready)
//
// One byte per cycle sustained while rsp_ch is not stalled; a taken byte goes into
// the input register, then through the parser into the result register.
// Reset clears phase, counters and both stage valids; CSRs go to 0x28 and 40.
// A stalled rsp_ch holds the result; the input stage keeps taking bytes until
// it is also full, then req_ch ready drops.
module touch_frame_receiver
   import tfr_pkg::*;
#(
   parameter int unsigned PAYLOAD_DEPTH = 8
) (
   input logic clock,
   input logic reset,
   tfr_chan_if.sink   req_ch,
   tfr_chan_if.source rsp_ch,
   tfr_chan_if.sink   csr_ch
);

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_byte_ff;
   logic          out_free;
   logic          s1_adv;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type  rsp_beat_ff;
   parse_res_type res;
   logic [7:0]    key_opcode_ff;
   logic [8:0]    key_limit_ff;
   req_beat_type  req_beat;
   csr_beat_type  csr_beat;

   assign req_beat = req_ch.payload;
   assign csr_beat = csr_ch.payload;

   // Handshake flow between the two stages
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign s1_valid_in  = (req_ch.valid && req_ch.ready) || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv ? res.valid : (rsp_valid_ff && !rsp_ch.ready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         s1_byte_ff <= req_beat.rx_byte;
      end
   end

   tfr_parser #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_adv),
      .rx_byte    (s1_byte_ff),
      .key_opcode (key_opcode_ff),
      .key_limit  (key_limit_ff),
      .res        (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv && res.valid) begin
         rsp_beat_ff <= res.beat;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_beat_ff;

   // Configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_opcode_ff <= KEY_OPCODE_RESET;
         key_limit_ff  <= KEY_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         if (csr_beat.index == REG_KEY_OPCODE) key_opcode_ff <= csr_beat.data[7:0];
         if (csr_beat.index == REG_KEY_LIMIT)  key_limit_ff  <= csr_beat.data;
      end
   end

   // Checks
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_toolong_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_beat_ff.frame_status == ST_TOOLONG) |->
      (rsp_beat_ff.key_code == 8'd0 && rsp_beat_ff.command_byte == 8'd0))
      else $error("length error beat carries payload");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_byte_ff)))
      else $error("input stage lost a byte under stall");

   a_result_not_dropped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff)
      else $error("stalled result dropped");

endmodule
